// ===== rtl/tgd_pkg.sv =====
`default_nettype none

package tgd_pkg;

    // Every glyph of the font is five columns wide.
    localparam int GLYPH_WIDTH = 5;

    // Controller command codes and character codes.
    localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;
    localparam logic [7:0] NEWLINE         = 8'h0A;
    localparam logic [7:0] BLANK_COLUMN    = 8'h00;

    // One input item.
    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [3:0] page_request;
        logic [7:0] column_request;
    } char_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } byte_item_t;

    // Work handed from the front to the back: an optional address window,
    // then an optional glyph with its five columns (column 0 in the top byte).
    typedef struct packed {
        logic        show_window;
        logic [7:0]  window_column;
        logic [2:0]  window_page;
        logic        show_glyph;
        logic [39:0] glyph;
    } job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic can_push;
        logic has_item;
    } queue_status_t;

    // Byte positions within the output sequence of one job.
    typedef enum logic [3:0] {
        STEP_COL_CMD,
        STEP_COL_START,
        STEP_COL_END,
        STEP_PAGE_CMD,
        STEP_PAGE_START,
        STEP_PAGE_END,
        STEP_GLYPH_0,
        STEP_GLYPH_1,
        STEP_GLYPH_2,
        STEP_GLYPH_3,
        STEP_GLYPH_4,
        STEP_SPACER
    } step_t;

    // Font table: one row per printable character starting at the space.
    function automatic logic [39:0] glyph_columns(input logic [6:0] row);
        logic [39:0] g;
        case (row)
            7'd0:    g = 40'h0000000000;
            7'd1:    g = 40'h00002f0000;
            7'd2:    g = 40'h0007000700;
            7'd3:    g = 40'h147f147f14;
            7'd4:    g = 40'h242a7f2a12;
            7'd5:    g = 40'h2313086462;
            7'd6:    g = 40'h3649552250;
            7'd7:    g = 40'h0005030000;
            7'd8:    g = 40'h001c224100;
            7'd9:    g = 40'h0041221c00;
            7'd10:   g = 40'h14083e0814;
            7'd11:   g = 40'h08083e0808;
            7'd12:   g = 40'h0000a06000;
            7'd13:   g = 40'h0808080808;
            7'd14:   g = 40'h0060600000;
            7'd15:   g = 40'h2010080402;
            7'd16:   g = 40'h3e5149453e;
            7'd17:   g = 40'h00427f4000;
            7'd18:   g = 40'h4261514946;
            7'd19:   g = 40'h2141454b31;
            7'd20:   g = 40'h1814127f10;
            7'd21:   g = 40'h2745454539;
            7'd22:   g = 40'h3c4a494930;
            7'd23:   g = 40'h0171090503;
            7'd24:   g = 40'h3649494936;
            7'd25:   g = 40'h064949291e;
            7'd26:   g = 40'h0036360000;
            7'd27:   g = 40'h0056360000;
            7'd28:   g = 40'h0814224100;
            7'd29:   g = 40'h1414141414;
            7'd30:   g = 40'h0041221408;
            7'd31:   g = 40'h0201510906;
            7'd32:   g = 40'h324959513e;
            7'd33:   g = 40'h7c1211127c;
            7'd34:   g = 40'h7f49494936;
            7'd35:   g = 40'h3e41414122;
            7'd36:   g = 40'h7f4141221c;
            7'd37:   g = 40'h7f49494941;
            7'd38:   g = 40'h7f09090901;
            7'd39:   g = 40'h3e4149497a;
            7'd40:   g = 40'h7f0808087f;
            7'd41:   g = 40'h00417f4100;
            7'd42:   g = 40'h2040413f01;
            7'd43:   g = 40'h7f08142241;
            7'd44:   g = 40'h7f40404040;
            7'd45:   g = 40'h7f020c027f;
            7'd46:   g = 40'h7f0408107f;
            7'd47:   g = 40'h3e4141413e;
            7'd48:   g = 40'h7f09090906;
            7'd49:   g = 40'h3e4151215e;
            7'd50:   g = 40'h7f09192946;
            7'd51:   g = 40'h4649494931;
            7'd52:   g = 40'h01017f0101;
            7'd53:   g = 40'h3f4040403f;
            7'd54:   g = 40'h1f2040201f;
            7'd55:   g = 40'h3f4038403f;
            7'd56:   g = 40'h6314081463;
            7'd57:   g = 40'h0708700807;
            7'd58:   g = 40'h6151494543;
            7'd59:   g = 40'h007f414100;
            7'd60:   g = 40'h55aa55aa55;
            7'd61:   g = 40'h0041417f00;
            7'd62:   g = 40'h0402010204;
            7'd63:   g = 40'h4040404040;
            7'd64:   g = 40'h0003050000;
            7'd65:   g = 40'h2054545478;
            7'd66:   g = 40'h7f48444438;
            7'd67:   g = 40'h3844444420;
            7'd68:   g = 40'h384444487f;
            7'd69:   g = 40'h3854545418;
            7'd70:   g = 40'h087e090102;
            7'd71:   g = 40'h18a4a4a47c;
            7'd72:   g = 40'h7f08040478;
            7'd73:   g = 40'h00447d4000;
            7'd74:   g = 40'h4080847d00;
            7'd75:   g = 40'h7f10284400;
            7'd76:   g = 40'h00417f4000;
            7'd77:   g = 40'h7c04180478;
            7'd78:   g = 40'h7c08040478;
            7'd79:   g = 40'h3844444438;
            7'd80:   g = 40'hfc24242418;
            7'd81:   g = 40'h18242418fc;
            7'd82:   g = 40'h7c08040408;
            7'd83:   g = 40'h4854545420;
            7'd84:   g = 40'h043f444020;
            7'd85:   g = 40'h3c4040207c;
            7'd86:   g = 40'h1c2040201c;
            7'd87:   g = 40'h3c4030403c;
            7'd88:   g = 40'h4428102844;
            7'd89:   g = 40'h1ca0a0a07c;
            7'd90:   g = 40'h4464544c44;
            7'd91:   g = 40'h00107c8200;
            7'd92:   g = 40'h0000ff0000;
            7'd93:   g = 40'h00827c1000;
            7'd94:   g = 40'h0006090906;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tgd_channels_if.sv =====
`default_nettype none

// Character channel into the block.
interface tgd_char_if;
    logic                  valid;
    logic                  ready;
    tgd_pkg::char_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Byte channel toward the display controller.
interface tgd_byte_if;
    logic                  valid;
    logic                  ready;
    tgd_pkg::byte_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgd_front.sv =====
`default_nettype none

module tgd_front #(
    parameter int COLUMNS   = 128,
    parameter int LAST_PAGE = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tgd_char_if.sink                    char_in,
    input  wire tgd_pkg::queue_status_t status,
    output logic                        push,
    output tgd_pkg::job_t               job
);

    logic [2:0]  page_reg;
    logic [2:0]  page_next;
    logic [7:0]  column_reg;
    logic [7:0]  column_next;
    logic        accept;
    logic        is_newline;
    logic        wrap;
    logic        cursor_ok;
    logic        printable;
    logic [2:0]  wrapped_page;
    logic [7:0]  base_column;
    logic [6:0]  glyph_row;

    // A transfer is taken whenever the queue has room.
    assign char_in.ready = status.can_push;
    assign accept        = char_in.valid && char_in.ready;

    // Classification of the incoming character.
    assign is_newline = (char_in.data.char_code == tgd_pkg::NEWLINE);
    assign wrap       = (9'(column_reg) + 9'(tgd_pkg::GLYPH_WIDTH) >= 9'(COLUMNS))
                        || is_newline;
    assign cursor_ok  = (char_in.data.page_request <= 4'(LAST_PAGE))
                        && (9'(char_in.data.column_request) < 9'(COLUMNS));
    assign printable  = (char_in.data.char_code >= tgd_pkg::FIRST_PRINTABLE)
                        && (char_in.data.char_code <= tgd_pkg::LAST_PRINTABLE);
    assign glyph_row  = 7'(char_in.data.char_code - tgd_pkg::FIRST_PRINTABLE);

    // Page after a wrap, rolling over past the last page.
    assign wrapped_page = (page_reg >= 3'(LAST_PAGE)) ? 3'd0 : page_reg + 3'd1;
    assign base_column  = wrap ? 8'd0 : column_reg;

    // Cursor update and job build.
    always_comb
    begin
        page_next         = page_reg;
        column_next       = column_reg;
        push              = 1'b0;
        job.show_window   = 1'b0;
        job.window_column = 8'd0;
        job.window_page   = 3'd0;
        job.show_glyph    = 1'b0;
        job.glyph         = 40'd0;
        if (char_in.data.command)
        begin
            job.show_window   = 1'b1;
            job.window_column = char_in.data.column_request;
            job.window_page   = char_in.data.page_request[2:0];
            if (accept && cursor_ok)
            begin
                push        = 1'b1;
                page_next   = char_in.data.page_request[2:0];
                column_next = char_in.data.column_request;
            end
        end
        else
        begin
            job.show_window   = wrap;
            job.window_column = 8'd0;
            job.window_page   = wrapped_page;
            job.show_glyph    = !is_newline;
            job.glyph         = printable ? tgd_pkg::glyph_columns(glyph_row) : 40'd0;
            if (accept)
            begin
                push      = 1'b1;
                page_next = wrap ? wrapped_page : page_reg;
                column_next = is_newline ? base_column
                            : base_column + 8'(tgd_pkg::GLYPH_WIDTH + 1);
            end
        end
    end

    // Cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg   <= 3'd0;
            column_reg <= 8'd0;
        end
        else
        begin
            page_reg   <= page_next;
            column_reg <= column_next;
        end
    end

    // The cursor never runs past the last page or beyond the screen width.
    a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg <= 3'(LAST_PAGE))
        else $error("page cursor beyond last page");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        9'(column_reg) <= 9'(COLUMNS))
        else $error("column cursor beyond screen width");

endmodule

`default_nettype wire

// ===== rtl/tgd_queue.sv =====
`default_nettype none

module tgd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tgd_pkg::job_t      push_job,
    input  wire logic               pop,
    output tgd_pkg::job_t           head,
    output tgd_pkg::queue_status_t  status
);

    tgd_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign head            = slot_reg[rd_ptr_reg];
    assign status.has_item = (count_reg != 2'd0);
    assign status.can_push = (count_reg != 2'd2);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The fill count must follow the pointers.
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue fill count disagrees with pointers");

endmodule

`default_nettype wire

// ===== rtl/tgd_back.sv =====
`default_nettype none

module tgd_back #(
    parameter int COLUMNS   = 128,
    parameter int LAST_PAGE = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tgd_pkg::job_t          head,
    input  wire tgd_pkg::queue_status_t status,
    output logic                        pop,
    tgd_byte_if.source                  byte_out
);

    tgd_pkg::step_t      step_reg;
    tgd_pkg::step_t      step_next;
    logic                started_reg;
    logic                started_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    tgd_pkg::byte_item_t out_item_reg;
    tgd_pkg::byte_item_t out_item_next;
    tgd_pkg::step_t      start_step;
    tgd_pkg::step_t      end_step;
    tgd_pkg::step_t      cur_step;
    logic                load;
    logic [7:0]          cur_byte;

    // Where the head job's sequence begins and ends.
    assign start_step = head.show_window ? tgd_pkg::STEP_COL_CMD : tgd_pkg::STEP_GLYPH_0;
    assign end_step   = head.show_glyph ? tgd_pkg::STEP_SPACER : tgd_pkg::STEP_PAGE_END;
    assign cur_step   = started_reg ? step_reg : start_step;

    // A byte moves into the output register when it is empty or being drained.
    assign load = status.has_item && (!out_valid_reg || byte_out.ready);
    assign pop  = load && (cur_step == end_step);

    // Byte selection for the current step.
    always_comb
    begin
        case (cur_step)
            tgd_pkg::STEP_COL_CMD:    cur_byte = tgd_pkg::CMD_COL_WINDOW;
            tgd_pkg::STEP_COL_START:  cur_byte = head.window_column;
            tgd_pkg::STEP_COL_END:    cur_byte = 8'(COLUMNS - 1);
            tgd_pkg::STEP_PAGE_CMD:   cur_byte = tgd_pkg::CMD_PAGE_WINDOW;
            tgd_pkg::STEP_PAGE_START: cur_byte = {5'd0, head.window_page};
            tgd_pkg::STEP_PAGE_END:   cur_byte = 8'(LAST_PAGE);
            tgd_pkg::STEP_GLYPH_0:    cur_byte = head.glyph[39:32];
            tgd_pkg::STEP_GLYPH_1:    cur_byte = head.glyph[31:24];
            tgd_pkg::STEP_GLYPH_2:    cur_byte = head.glyph[23:16];
            tgd_pkg::STEP_GLYPH_3:    cur_byte = head.glyph[15:8];
            tgd_pkg::STEP_GLYPH_4:    cur_byte = head.glyph[7:0];
            default:                  cur_byte = tgd_pkg::BLANK_COLUMN;
        endcase
    end

    // Sequencer and output register next state.
    always_comb
    begin
        step_next      = step_reg;
        started_next   = started_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_byte = cur_byte;
            out_item_next.is_data  = (cur_step >= tgd_pkg::STEP_GLYPH_0);
            out_item_next.last     = (cur_step == end_step);
            if (cur_step == end_step)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                step_next    = tgd_pkg::step_t'(cur_step + 4'd1);
            end
        end
        else if (byte_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= tgd_pkg::STEP_COL_CMD;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign byte_out.valid = out_valid_reg;
    assign byte_out.data  = out_item_reg;

    // After the final byte of a job the next job starts from its first step.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_item_next.last) |=> !started_reg)
        else $error("sequencer did not restart after final byte");

endmodule

`default_nettype wire

// ===== rtl/text_glyph_display_stream.sv =====
// Text renderer for a page-addressed monochrome display controller.
// char_in takes one character or set-cursor item per transfer; byte_out
// delivers the controller byte stream, each byte flagged as data or command,
// with last set on the final byte caused by an item.
// A set-cursor item in range gives six command bytes (the address window);
// one out of range gives nothing. A printed character gives six data bytes,
// preceded by the six window bytes when the line wraps; a newline gives the
// six window bytes only.
// The first byte of an item is registered in the job queue and then in the
// output register before it appears on byte_out.
// Throughput: one byte per cycle while byte_out is ready and a job is queued,
// set by the single output register.
// A two-entry job queue sits between the input classifier and the byte
// sequencer, so the next items are taken while earlier bytes drain.
// Reset puts the cursor at page 0, column 0 and empties the queue and the
// output register. When the receiver stalls, the held byte stays on byte_out,
// the sequencer waits, and char_in stops taking items once the queue is full.
`default_nettype none

module text_glyph_display_stream #(
    parameter int COLUMNS   = 128,
    parameter int LAST_PAGE = 7
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tgd_char_if.sink    char_in,
    tgd_byte_if.source  byte_out
);

    tgd_pkg::job_t          front_job;
    tgd_pkg::job_t          queue_head;
    tgd_pkg::queue_status_t queue_status;
    logic                   front_push;
    logic                   back_pop;

    // Classifier and cursor tracking.
    tgd_front #(
        .COLUMNS   (COLUMNS),
        .LAST_PAGE (LAST_PAGE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .status  (queue_status),
        .push    (front_push),
        .job     (front_job)
    );

    // Job queue between the two halves.
    tgd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .pop      (back_pop),
        .head     (queue_head),
        .status   (queue_status)
    );

    // Byte sequencer and output register.
    tgd_back #(
        .COLUMNS   (COLUMNS),
        .LAST_PAGE (LAST_PAGE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (queue_head),
        .status   (queue_status),
        .pop      (back_pop),
        .byte_out (byte_out)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

    localparam int COLUMNS = 128;
    localparam int LAST_PAGE = 7;

    // Command codes carried in the command field.
    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_SET_CURSOR = 1'b1;

    // The first byte of an item passes the job queue and the output register; allow margin.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    // Length of the deliberate receiver hold-off.
    localparam int LONG_HOLD_CYCLES = 250;

    // Font columns per printable character, leftmost column in the top byte.
    localparam logic [39:0] FONT_COLUMNS [0:94] = '{
        40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
        40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
        40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
        40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
        40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
        40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
        40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
        40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
    };

    logic clk;
    logic rst_n;

    tgd_char_if char_ch ();
    tgd_byte_if byte_ch ();

    text_glyph_display_stream #(
        .COLUMNS   (COLUMNS),
        .LAST_PAGE (LAST_PAGE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .byte_out (byte_ch)
    );

    // Cursor as the predictor sees it.
    logic [2:0] cursor_page;
    logic [7:0] cursor_column;

    // Bytes still owed by the block, oldest first.
    tgd_pkg::byte_item_t pending_bytes [$];

    int errors;
    int chars_taken;
    int bytes_matched;
    int line_wraps;
    int cursor_moves;
    int cursor_rejects;

    // Idling controls for the stimulus and the receiver, and the watchdog's idle count.
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_left;
    bit byte_taken;
    int idle_cycles;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append one expected byte.
    task automatic owe_byte(input logic [7:0] value, input logic data_flag);
        tgd_pkg::byte_item_t b;
        b.out_byte = value;
        b.is_data = data_flag;
        b.last = 1'b0;
        pending_bytes.push_back(b);
    endtask

    // The address window reflects the cursor after it has been updated.
    task automatic owe_window();
        owe_byte(tgd_pkg::CMD_COL_WINDOW, 1'b0);
        owe_byte(cursor_column, 1'b0);
        owe_byte(8'(COLUMNS - 1), 1'b0);
        owe_byte(tgd_pkg::CMD_PAGE_WINDOW, 1'b0);
        owe_byte({5'd0, cursor_page}, 1'b0);
        owe_byte(8'(LAST_PAGE), 1'b0);
    endtask

    // Work out the bytes one character item produces and advance the cursor.
    task automatic render_char(input tgd_pkg::char_item_t it);
        int first_new;
        logic printable;
        logic [39:0] columns;
        first_new = pending_bytes.size();
        if (it.command == CMD_SET_CURSOR)
        begin
            if (int'(it.page_request) <= LAST_PAGE && int'(it.column_request) < COLUMNS)
            begin
                cursor_page = it.page_request[2:0];
                cursor_column = it.column_request;
                owe_window();
                cursor_moves++;
            end
            else
                cursor_rejects++;
        end
        else
        begin
            // Wrap once, whether on newline, on the right edge, or both.
            if (int'(cursor_column) + tgd_pkg::GLYPH_WIDTH >= COLUMNS
                || it.char_code == tgd_pkg::NEWLINE)
            begin
                if (int'(cursor_page) >= LAST_PAGE)
                    cursor_page = 3'd0;
                else
                    cursor_page = cursor_page + 3'd1;
                cursor_column = 8'd0;
                owe_window();
                line_wraps++;
            end
            if (it.char_code != tgd_pkg::NEWLINE)
            begin
                printable = (it.char_code >= tgd_pkg::FIRST_PRINTABLE)
                            && (it.char_code <= tgd_pkg::LAST_PRINTABLE);
                columns = printable ? FONT_COLUMNS[it.char_code - tgd_pkg::FIRST_PRINTABLE]
                                    : 40'd0;
                for (int i = 0; i < tgd_pkg::GLYPH_WIDTH; i++)
                    owe_byte(columns[39 - 8 * i -: 8], 1'b1);
                owe_byte(tgd_pkg::BLANK_COLUMN, 1'b1);
                cursor_column = cursor_column + 8'(tgd_pkg::GLYPH_WIDTH + 1);
            end
        end
        if (pending_bytes.size() > first_new)
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endtask

    // Predict on every transfer into the block.
    always @(posedge clk)
    begin
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            render_char(char_ch.data);
            chars_taken++;
        end
    end

    // Check every transfer out of the block against the oldest expectation.
    always @(posedge clk)
    begin
        tgd_pkg::byte_item_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            byte_taken = 1'b1;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte %h (is_data %b, last %b)",
                       byte_ch.data.out_byte, byte_ch.data.is_data, byte_ch.data.last);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_ch.data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, byte_ch.data.out_byte);
                    errors++;
                end
                if (byte_ch.data.is_data !== want.is_data)
                begin
                    $error("is_data: expected %b, got %b", want.is_data, byte_ch.data.is_data);
                    errors++;
                end
                if (byte_ch.data.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, byte_ch.data.last);
                    errors++;
                end
                bytes_matched++;
            end
        end
    end

    // Receiver: random wait per byte, plus an optional long hold-off.
    initial
    begin
        int rx_wait;
        rx_wait = 0;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (byte_taken)
            begin
                byte_taken = 1'b0;
                rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                byte_ch.ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                byte_ch.ready <= 1'b0;
            end
            else
                byte_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (byte_ch.valid && byte_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** text_glyph_display_stream: FAILED **");
            $finish;
        end
    end

    function automatic tgd_pkg::char_item_t make_item(input logic cmd, input logic [7:0] code,
                                                      input logic [3:0] page,
                                                      input logic [7:0] col);
        tgd_pkg::char_item_t it;
        it.command = cmd;
        it.char_code = code;
        it.page_request = page;
        it.column_request = col;
        return it;
    endfunction

    function automatic tgd_pkg::char_item_t print_of(input logic [7:0] code);
        return make_item(CMD_PRINT, code, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endfunction

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(input tgd_pkg::char_item_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.data <= it;
        do
            @(posedge clk);
        while (!char_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed byte has arrived.
    task automatic wait_for_results();
        char_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Cursor positions at the corners and beyond the screen.
    task automatic test_cursor_extremes();
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'd0, 8'd0));
        send_item(make_item(CMD_SET_CURSOR, 8'hff, 4'(LAST_PAGE), 8'(COLUMNS - 1)));
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'(LAST_PAGE + 1), 8'd0));
        send_item(make_item(CMD_SET_CURSOR, 8'hff, 4'd15, 8'd255));
        send_item(make_item(CMD_SET_CURSOR, 8'h55, 4'd0, 8'(COLUMNS)));
        send_item(make_item(CMD_SET_CURSOR, 8'haa, 4'(LAST_PAGE), 8'd255));
        send_item(make_item(CMD_SET_CURSOR, 8'h0a, 4'd5, 8'd64));
        wait_for_results();
    endtask

    // Glyph table ends, unprintable codes, newline and both kinds of wrap.
    task automatic test_glyph_edges();
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'd0, 8'd0));
        send_item(print_of(tgd_pkg::FIRST_PRINTABLE));
        send_item(print_of(tgd_pkg::LAST_PRINTABLE));
        send_item(print_of(tgd_pkg::FIRST_PRINTABLE - 8'd1));
        send_item(print_of(tgd_pkg::LAST_PRINTABLE + 8'd1));
        send_item(print_of(8'h00));
        send_item(print_of(8'hff));
        send_item(print_of(8'h41));
        send_item(print_of(tgd_pkg::NEWLINE));
        // Right edge reached exactly.
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'd3, 8'(COLUMNS - tgd_pkg::GLYPH_WIDTH)));
        send_item(print_of(8'h42));
        // Last glyph that still fits, then the one that wraps from the last page.
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'(LAST_PAGE),
                            8'(COLUMNS - tgd_pkg::GLYPH_WIDTH - 1)));
        send_item(print_of(8'h43));
        send_item(print_of(8'h44));
        // Newline at the right edge wraps only once.
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'd2,
                            8'(COLUMNS - tgd_pkg::GLYPH_WIDTH + 1)));
        send_item(print_of(tgd_pkg::NEWLINE));
        // Newline on the last page goes back to the top.
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'(LAST_PAGE), 8'd0));
        send_item(print_of(tgd_pkg::NEWLINE));
        wait_for_results();
    endtask

    // Hold the receiver off while the sender keeps offering back to back.
    task automatic test_receiver_stall();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_left = LONG_HOLD_CYCLES;
        send_item(make_item(CMD_SET_CURSOR, 8'h00, 4'd6,
                            8'(COLUMNS - 2 * tgd_pkg::GLYPH_WIDTH)));
        for (int i = 0; i < 13; i++)
            send_item(print_of(8'($urandom_range(tgd_pkg::FIRST_PRINTABLE,
                                                 tgd_pkg::LAST_PRINTABLE))));
        wait_for_results();
    endtask

    // Mostly running text with random content, some cursor moves and noise.
    task automatic test_random_text(input int count);
        int r;
        int mode;
        tgd_pkg::char_item_t it;
        for (int i = 0; i < count; i++)
        begin
            // Change idling pattern every stretch, including stretches with none.
            if (i % 40 == 0)
            begin
                mode = $urandom_range(0, 3);
                tx_idle_on = mode[0];
                rx_idle_on = mode[1];
            end
            if (i % 120 == 119)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 68)
                it = print_of(8'($urandom_range(tgd_pkg::FIRST_PRINTABLE,
                                                tgd_pkg::LAST_PRINTABLE)));
            else if (r < 76)
                it = print_of(tgd_pkg::NEWLINE);
            else if (r < 84)
                it = print_of(8'($urandom_range(0, 255)));
            else if (r < 89)
                it = make_item(CMD_SET_CURSOR, 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, LAST_PAGE)),
                               8'($urandom_range(0, COLUMNS - 1)));
            else if (r < 95)
                it = make_item(CMD_SET_CURSOR, 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, LAST_PAGE)),
                               8'($urandom_range(COLUMNS - 2 * tgd_pkg::GLYPH_WIDTH,
                                                 COLUMNS - 1)));
            else
                it = make_item(CMD_SET_CURSOR, 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            send_item(it);
        end
        wait_for_results();
    endtask

    initial
    begin
        errors = 0;
        chars_taken = 0;
        bytes_matched = 0;
        line_wraps = 0;
        cursor_moves = 0;
        cursor_rejects = 0;
        idle_cycles = 0;
        byte_taken = 1'b0;
        rx_hold_left = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        cursor_page = 3'd0;
        cursor_column = 8'd0;
        rst_n = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.data = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_cursor_extremes();
        test_glyph_edges();
        test_receiver_stall();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_text(390);

        if (pending_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", pending_bytes.size());
            errors++;
        end

        $display("Covered %0d character items and %0d bytes: %0d line wraps,",
                 chars_taken, bytes_matched, line_wraps);
        $display("%0d cursor moves, %0d rejected cursor requests, %0d mismatches.",
                 cursor_moves, cursor_rejects, errors);
        if (errors == 0)
            $display("** text_glyph_display_stream: PASSED **");
        else
            $display("** text_glyph_display_stream: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/tgd_pkg.sv
rtl/tgd_channels_if.sv
rtl/tgd_front.sv
rtl/tgd_queue.sv
rtl/tgd_back.sv
rtl/text_glyph_display_stream.sv
tb/testbench.sv
